>>> hw/rtl/sop_pkg.sv
// ----------------------------------------------------------------------------
// sop_pkg
// shared types and constants of the sphere overlap push-out datapath
// ----------------------------------------------------------------------------
package sop_pkg;

	localparam int CoordW = 32;                 // signed q16.16 coordinate
	localparam int RadW   = 31;                 // unsigned q15.16 radius
	localparam int RangeW = RadW + 1;           // sum of two radii
	localparam int MagW   = CoordW;             // magnitude of a centre difference
	localparam int NormW  = 31;                 // normalized magnitude, msb at bit 30
	localparam int SqW    = 64;                 // sum of normalized squares
	localparam int LenW   = SqW / 2;            // floor square root of the sum
	localparam int QuoW   = 34;                 // offset magnitude
	localparam int ResW   = QuoW + 2;           // signed sum before saturation

	localparam int SqrtIterPerStage = 2;
	localparam int IsqrtStages      = LenW / SqrtIterPerStage;
	localparam int DivIterPerStage  = 2;
	localparam int DivStages        = QuoW / DivIterPerStage;

	// front stages, root, multiply, numerator, divider, output register
	localparam int Latency = 6 + IsqrtStages + 2 + DivStages + 1;

	typedef struct packed {
		logic signed [CoordW-1:0] a_x;
		logic signed [CoordW-1:0] a_y;
		logic signed [CoordW-1:0] a_z;
		logic        [RadW-1:0]   radius_a;
		logic signed [CoordW-1:0] b_x;
		logic signed [CoordW-1:0] b_y;
		logic signed [CoordW-1:0] b_z;
		logic        [RadW-1:0]   radius_b;
	} req_t;

	typedef struct packed {
		logic                     hit;
		logic signed [CoordW-1:0] pushed_x;
		logic signed [CoordW-1:0] pushed_y;
		logic signed [CoordW-1:0] pushed_z;
	} rsp_t;

	// per item data that rides along the whole pipe
	typedef struct packed {
		logic [2:0][CoordW-1:0] a;
		logic [2:0][CoordW-1:0] b;
		logic [2:0]             neg;
		logic [RangeW-1:0]      range;
		logic                   hit;
		logic                   zero;
	} side_t;

	// what rides along the square root unit
	typedef struct packed {
		side_t                 side;
		logic [2:0][NormW-1:0] un;
	} isq_side_t;

endpackage

>>> hw/rtl/sop_isqrt.sv
// ----------------------------------------------------------------------------
// sop_isqrt
// pipelined floor square root, two root bits per stage
// ----------------------------------------------------------------------------
module sop_isqrt
	import sop_pkg::*;
#(
	parameter int SideW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  logic [SqW-1:0]   in_rad,
	input  logic [SideW-1:0] in_side,
	output logic             out_vld,
	output logic [LenW-1:0]  out_root,
	output logic [SideW-1:0] out_side
);

	logic             vld_s  [0:IsqrtStages];
	logic [LenW+2:0]  rem_s  [0:IsqrtStages];
	logic [LenW-1:0]  root_s [0:IsqrtStages];
	logic [SqW-1:0]   rad_s  [0:IsqrtStages];
	logic [SideW-1:0] side_s [0:IsqrtStages];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = in_rad;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < IsqrtStages; k++) begin : g_stage
		logic [LenW+2:0] rem_c;
		logic [LenW-1:0] root_c;
		logic [SqW-1:0]  rad_c;

		always_comb begin
			logic [LenW+2:0] r;
			logic [LenW+2:0] t;
			logic [LenW-1:0] q;
			logic [SqW-1:0]  x;
			r = rem_s[k];
			q = root_s[k];
			x = rad_s[k];
			for (int j = 0; j < SqrtIterPerStage; j++) begin
				r = {r[LenW:0], x[SqW-1:SqW-2]};
				t = {1'b0, q, 2'b01};
				if (r >= t) begin
					r = r - t;
					q = {q[LenW-2:0], 1'b1};
				end else begin
					q = {q[LenW-2:0], 1'b0};
				end
				x = {x[SqW-3:0], 2'b00};
			end
			rem_c  = r;
			root_c = q;
			rad_c  = x;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k+1] <= 1'b0;
			else         vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= rem_c;
			root_s[k+1] <= root_c;
			rad_s[k+1]  <= rad_c;
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_vld  = vld_s[IsqrtStages];
	assign out_root = root_s[IsqrtStages];
	assign out_side = side_s[IsqrtStages];

endmodule

>>> hw/rtl/sop_div.sv
// ----------------------------------------------------------------------------
// sop_div
// pipelined restoring divider, three lanes sharing one divisor
// ----------------------------------------------------------------------------
module sop_div
	import sop_pkg::*;
#(
	parameter int SideW = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_vld,
	input  logic [2:0][SqW-1:0]   in_num,
	input  logic [LenW-1:0]       in_den,
	input  logic [SideW-1:0]      in_side,
	output logic                  out_vld,
	output logic [2:0][QuoW-1:0]  out_quo,
	output logic [SideW-1:0]      out_side
);

	logic                  vld_s  [0:DivStages];
	logic [2:0][LenW:0]    rem_s  [0:DivStages];
	logic [2:0][QuoW-1:0]  nb_s   [0:DivStages];
	logic [2:0][QuoW-1:0]  quo_s  [0:DivStages];
	logic [LenW-1:0]       den_s  [0:DivStages];
	logic [SideW-1:0]      side_s [0:DivStages];

	// the quotient fits QuoW bits, so the top bits start as the remainder
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rem_s[0][i] = (LenW+1)'(in_num[i][SqW-1:QuoW]);
			nb_s[0][i]  = in_num[i][QuoW-1:0];
		end
	end
	assign vld_s[0]  = in_vld;
	assign quo_s[0]  = '0;
	assign den_s[0]  = in_den;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < DivStages; k++) begin : g_stage
		logic [2:0][LenW:0]   rem_c;
		logic [2:0][QuoW-1:0] nb_c;
		logic [2:0][QuoW-1:0] quo_c;

		always_comb begin
			logic [LenW:0]   r;
			logic [QuoW-1:0] x;
			logic [QuoW-1:0] q;
			logic [LenW:0]   d;
			d = {1'b0, den_s[k]};
			for (int i = 0; i < 3; i++) begin
				r = rem_s[k][i];
				x = nb_s[k][i];
				q = quo_s[k][i];
				for (int j = 0; j < DivIterPerStage; j++) begin
					r = {r[LenW-1:0], x[QuoW-1]};
					x = {x[QuoW-2:0], 1'b0};
					if (r >= d) begin
						r = r - d;
						q = {q[QuoW-2:0], 1'b1};
					end else begin
						q = {q[QuoW-2:0], 1'b0};
					end
				end
				rem_c[i] = r;
				nb_c[i]  = x;
				quo_c[i] = q;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k+1] <= 1'b0;
			else         vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= rem_c;
			nb_s[k+1]   <= nb_c;
			quo_s[k+1]  <= quo_c;
			den_s[k+1]  <= den_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_vld  = vld_s[DivStages];
	assign out_quo  = quo_s[DivStages];
	assign out_side = side_s[DivStages];

endmodule

>>> hw/rtl/sphere_overlap_pushout_top.sv
// ----------------------------------------------------------------------------
// sphere_overlap_pushout_top
// sphere against sphere overlap test with push-out of the second centre
// ----------------------------------------------------------------------------
// usage
//   one input word (req) holds two spheres, centres in signed q16.16 and
//   radii in unsigned q15.16; it is taken at a clock edge where start is
//   high and busy is low. busy is always low: a new word can be taken at
//   every edge, so throughput is one pair per cycle
//   each word gives exactly one result word on rsp, marked by done for a
//   single cycle, in input order
//   the latency is set by the 16 stage square root and the 17 stage
//   divider, two bits of each per stage, plus the front and back stages
//   the receiver cannot stall: the pipe always moves and nothing waits
//   reset clears only the valid bits; no result comes out of a word that
//   was in flight when reset was applied
//   hit says the spheres overlap or touch; pushed_* is the pushed centre of
//   b on a hit, b itself on a miss and a when the centres coincide
// ----------------------------------------------------------------------------
module sphere_overlap_pushout_top
	import sop_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	localparam int IsqSideW = $bits(isq_side_t);
	localparam int DivSideW = $bits(side_t);

	logic in_acc;

	// never holds off: every stage moves each cycle
	assign busy   = 1'b0;
	assign in_acc = start & ~busy;

	// ---- stage 1: centre differences split into sign and magnitude
	logic [2:0][CoordW-1:0] a_c, b_c;
	logic [2:0][CoordW:0]   diff_c;
	logic [2:0][MagW-1:0]   mag_c;
	logic [2:0]             neg_c;
	logic [RangeW-1:0]      range_c;

	assign a_c     = {req.a_z, req.a_y, req.a_x};
	assign b_c     = {req.b_z, req.b_y, req.b_x};
	assign range_c = {1'b0, req.radius_a} + {1'b0, req.radius_b};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff_c[i] = {b_c[i][CoordW-1], b_c[i]} - {a_c[i][CoordW-1], a_c[i]};
			neg_c[i]  = diff_c[i][CoordW];
			mag_c[i]  = neg_c[i] ? MagW'(-diff_c[i]) : diff_c[i][MagW-1:0];
		end
	end

	logic                 vld_s1;
	side_t                side_s1;
	logic [2:0][MagW-1:0] u_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= in_acc;
	end

	always_ff @(posedge clk) begin
		side_s1.a     <= a_c;
		side_s1.b     <= b_c;
		side_s1.neg   <= neg_c;
		side_s1.range <= range_c;
		side_s1.hit   <= 1'b0;
		side_s1.zero  <= 1'b0;
		u_s1          <= mag_c;
	end

	// ---- stage 2: squared magnitudes, squared radius sum, largest axis
	logic [MagW-1:0] max_c;

	always_comb begin
		max_c = u_s1[0];
		if (u_s1[1] > max_c) max_c = u_s1[1];
		if (u_s1[2] > max_c) max_c = u_s1[2];
	end

	logic                 vld_s2;
	side_t                side_s2;
	logic [2:0][MagW-1:0] u_s2;
	logic [2:0][SqW-1:0]  sq_s2;
	logic [SqW-1:0]       rsq_s2;
	logic [MagW-1:0]      m_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s2[i] <= SqW'(u_s1[i]) * SqW'(u_s1[i]);
		end
		rsq_s2  <= SqW'(side_s1.range) * SqW'(side_s1.range);
		m_s2    <= max_c;
		u_s2    <= u_s1;
		side_s2 <= side_s1;
	end

	// ---- stage 3: exact overlap compare and normalizing shift amount
	logic [SqW+1:0] dist_c;
	logic           hit_c;
	logic [4:0]     msb_c;
	logic [4:0]     shl_c;
	side_t          side3_c;

	assign dist_c = (SqW+2)'(sq_s2[0]) + (SqW+2)'(sq_s2[1]) + (SqW+2)'(sq_s2[2]);
	assign hit_c  = dist_c <= (SqW+2)'(rsq_s2);

	// position of the leading one in bits 30:0; only used when bits 31:30 are clear
	always_comb begin
		msb_c = '0;
		for (int k = 0; k < NormW; k++) begin
			if (m_s2[k]) msb_c = 5'(k);
		end
		shl_c = 5'(5'(NormW - 1) - msb_c);
	end

	// side data with the compare outcome filled in
	always_comb begin
		side3_c      = side_s2;
		side3_c.hit  = hit_c;
		side3_c.zero = (m_s2 == '0);
	end

	logic                 vld_s3;
	side_t                side_s3;
	logic [2:0][MagW-1:0] u_s3;
	logic                 shr_s3;
	logic [4:0]           shl_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else         vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		side_s3 <= side3_c;
		u_s3    <= u_s2;
		shr_s3  <= m_s2[MagW-1];
		shl_s3  <= (m_s2[MagW-1] | m_s2[NormW-1]) ? 5'd0 : shl_c;
	end

	// ---- stage 4: scale all axes together, largest lands in [2^30, 2^31)
	logic                  vld_s4;
	side_t                 side_s4;
	logic [2:0][NormW-1:0] un_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else         vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			un_s4[i] <= shr_s3 ? u_s3[i][MagW-1:1] : NormW'(u_s3[i] << shl_s3);
		end
		side_s4 <= side_s3;
	end

	// ---- stage 5: squares of the normalized axes
	logic                      vld_s5;
	side_t                     side_s5;
	logic [2:0][NormW-1:0]     un_s5;
	logic [2:0][2*NormW-1:0]   nsq_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else         vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			nsq_s5[i] <= (2*NormW)'(un_s4[i]) * (2*NormW)'(un_s4[i]);
		end
		un_s5   <= un_s4;
		side_s5 <= side_s4;
	end

	// ---- stage 6: sum of squares feeding the square root
	logic                  vld_s6;
	side_t                 side_s6;
	logic [2:0][NormW-1:0] un_s6;
	logic [SqW-1:0]        s_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else         vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		s_s6    <= SqW'(nsq_s5[0]) + SqW'(nsq_s5[1]) + SqW'(nsq_s5[2]);
		un_s6   <= un_s5;
		side_s6 <= side_s5;
	end

	// ---- length of the normalized direction
	isq_side_t             isq_in;
	logic [IsqSideW-1:0]   isq_out_side;
	isq_side_t             isq_out;
	logic                  isq_vld;
	logic [LenW-1:0]       isq_root;

	assign isq_in.side = side_s6;
	assign isq_in.un   = un_s6;

	sop_isqrt #(
		.SideW (IsqSideW)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s6),
		.in_rad   (s_s6),
		.in_side  (isq_in),
		.out_vld  (isq_vld),
		.out_root (isq_root),
		.out_side (isq_out_side)
	);

	assign isq_out = isq_side_t'(isq_out_side);

	// ---- stage 7: axis times radius sum
	logic                         vld_s7;
	side_t                        side_s7;
	logic [LenW-1:0]              len_s7;
	logic [2:0][NormW+RangeW-1:0] prod_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else         vld_s7 <= isq_vld;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			prod_s7[i] <= (NormW+RangeW)'(isq_out.un[i]) *
			              (NormW+RangeW)'(isq_out.side.range);
		end
		len_s7  <= isq_root;
		side_s7 <= isq_out.side;
	end

	// ---- stage 8: add half the length so the quotient rounds half up
	logic                vld_s8;
	side_t               side_s8;
	logic [LenW-1:0]     len_s8;
	logic [2:0][SqW-1:0] num_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s8 <= 1'b0;
		else         vld_s8 <= vld_s7;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			num_s8[i] <= SqW'(prod_s7[i]) + SqW'(len_s7[LenW-1:1]);
		end
		len_s8  <= len_s7;
		side_s8 <= side_s7;
	end

	// ---- offsets along each axis
	logic [DivSideW-1:0]  div_out_side;
	side_t                div_side;
	logic                 div_vld;
	logic [2:0][QuoW-1:0] div_quo;

	sop_div #(
		.SideW (DivSideW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s8),
		.in_num   (num_s8),
		.in_den   (len_s8),
		.in_side  (side_s8),
		.out_vld  (div_vld),
		.out_quo  (div_quo),
		.out_side (div_out_side)
	);

	assign div_side = side_t'(div_out_side);

	// ---- stage 9: signed offset onto a, saturate, pick the result word
	logic [2:0][ResW-1:0]   sum_c;
	logic [2:0][CoordW-1:0] res_c;

	always_comb begin
		logic [ResW-1:0] off;
		logic [ResW-1:0] ax;
		logic [ResW-1:0] sat;
		for (int i = 0; i < 3; i++) begin
			off      = ResW'(div_quo[i]);
			ax       = {{(ResW-CoordW){div_side.a[i][CoordW-1]}}, div_side.a[i]};
			sum_c[i] = ax + (div_side.neg[i] ? (ResW'(0) - off) : off);
			sat      = sum_c[i];
			// out of range when the bits above the sign do not all agree
			if (sat[ResW-1:CoordW-1] != {(ResW-CoordW+1){sat[ResW-1]}}) begin
				res_c[i] = sat[ResW-1] ? {1'b1, {(CoordW-1){1'b0}}}
				                       : {1'b0, {(CoordW-1){1'b1}}};
			end else begin
				res_c[i] = sat[CoordW-1:0];
			end
			if (!div_side.hit)      res_c[i] = div_side.b[i];
			else if (div_side.zero) res_c[i] = div_side.a[i];
		end
	end

	logic vld_s9;
	rsp_t rsp_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s9 <= 1'b0;
		else         vld_s9 <= div_vld;
	end

	always_ff @(posedge clk) begin
		rsp_s9.hit      <= div_side.hit;
		rsp_s9.pushed_x <= res_c[0];
		rsp_s9.pushed_y <= res_c[1];
		rsp_s9.pushed_z <= res_c[2];
	end

	assign done = vld_s9;
	assign rsp  = rsp_s9;

	// ---- checks
	// every taken word comes out after the fixed latency
	a_lat_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> ##Latency done)
		else $error("word taken but no result after pipe latency");

	// no result without a word taken the same latency earlier
	a_lat_none: assert property (@(posedge clk) disable iff (!arst_n)
		!in_acc |-> ##Latency !done)
		else $error("result with no matching word");

	// normalization leaves the largest axis with bit 30 set
	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && side_s4.hit && !side_s4.zero) |->
		(un_s4[0][NormW-1] || un_s4[1][NormW-1] || un_s4[2][NormW-1]))
		else $error("normalized direction out of range");

	// the divisor is at least 2^30 for every word that uses the quotient
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s8 && side_s8.hit && !side_s8.zero) |-> (len_s8[LenW-1:LenW-2] != 2'b00))
		else $error("direction length below range");

endmodule
